/* src/ert_pkg.sv */
package ert_pkg;

    // Field and register widths
    localparam int NOW_W       = 64;
    localparam int TARGET_W    = 32;
    localparam int INTERVAL_W  = 16;
    localparam int PAUSE_W     = 30;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // Default event counter width
    localparam int COUNT_WIDTH_DEF = 64;

    // Signed accumulator for count*1e9 - rate*elapsed (products up to 96 bits)
    localparam int ACC_W = 98;

    // Nanoseconds per second, the largest pause
    localparam logic [PAUSE_W-1:0] NS_PER_SEC = 30'd1000000000;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_RATE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_INTERVAL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_TIME     = 2'd2;

    // Register reset values
    localparam logic [TARGET_W-1:0]   TARGET_RATE_RST    = 32'd1000;
    localparam logic [INTERVAL_W-1:0] CHECK_INTERVAL_RST = 16'd1;
    localparam logic [NOW_W-1:0]      START_TIME_RST     = 64'd0;

    // Settings the arithmetic side reads
    typedef struct packed {
        logic [TARGET_W-1:0] target_rate;
        logic [NOW_W-1:0]    start_time_ns;
    } t_rate_cfg;

endpackage

/* src/event_rate_throttle_unit.sv */
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-------------------------------
// event    | in        | i_in_valid / o_in_ready   | i_now_ns
// result   | out       | o_out_valid / i_out_ready | o_checked, o_pause_ns
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// An event word without a check passes through the queue into the output register. One that
// checks passes, in order, through a pop, the shared 32x32 multiplier, a compare, the radix-2
// divider and the output register. A check that gives no pause skips the divider.
// The front counts and classifies an event per cycle while the 2-word queue has room.
// A waiting result holds the output register; the back side runs on to its next result.
// Reset is synchronous, active low; the config port is always ready.
module event_rate_throttle_unit #(
    parameter int COUNT_WIDTH = ert_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ert_pkg::NOW_W-1:0]       i_now_ns,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_checked,
    output logic [ert_pkg::PAUSE_W-1:0]     o_pause_ns,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ert_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ert_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ert_pkg::*;

    localparam int Q_W = 1 + COUNT_WIDTH + NOW_W;

    logic [TARGET_W-1:0]    r_target_rate;
    logic [INTERVAL_W-1:0]  r_check_interval;
    logic [NOW_W-1:0]       r_start_time_ns;
    t_rate_cfg              w_cfg;

    logic                   w_push_valid;
    logic                   w_push_ready;
    logic                   w_push_checked;
    logic [COUNT_WIDTH-1:0] w_push_count;
    logic [NOW_W-1:0]       w_push_now;
    logic                   w_pop_valid;
    logic                   w_pop_ready;
    logic [Q_W-1:0]         w_pop_data;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_rate    <= TARGET_RATE_RST;
            r_check_interval <= CHECK_INTERVAL_RST;
            r_start_time_ns  <= START_TIME_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TARGET_RATE:    r_target_rate    <= i_cfg_data[TARGET_W-1:0];
                REG_CHECK_INTERVAL: r_check_interval <= i_cfg_data[INTERVAL_W-1:0];
                REG_START_TIME:     r_start_time_ns  <= i_cfg_data[NOW_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_cfg.target_rate   = r_target_rate;
    assign w_cfg.start_time_ns = r_start_time_ns;

    // Front: counting and check classification
    ert_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_now_ns         (i_now_ns),
        .i_check_interval (r_check_interval),
        .o_push_valid     (w_push_valid),
        .i_push_ready     (w_push_ready),
        .o_push_checked   (w_push_checked),
        .o_push_count     (w_push_count),
        .o_push_now       (w_push_now)
    );

    // Queue between the two sides
    ert_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  ({w_push_checked, w_push_count, w_push_now}),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    // Back: pause arithmetic and output register
    ert_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pop_valid    (w_pop_valid),
        .o_pop_ready    (w_pop_ready),
        .i_item_checked (w_pop_data[Q_W-1]),
        .i_item_count   (w_pop_data[NOW_W +: COUNT_WIDTH]),
        .i_item_now     (w_pop_data[NOW_W-1:0]),
        .i_cfg          (w_cfg),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_checked      (o_checked),
        .o_pause_ns     (o_pause_ns)
    );

endmodule

/* src/ert_front.sv */
module ert_front #(
    parameter int COUNT_WIDTH = ert_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ert_pkg::NOW_W-1:0]      i_now_ns,
    input  logic [ert_pkg::INTERVAL_W-1:0] i_check_interval,
    output logic                           o_push_valid,
    input  logic                           i_push_ready,
    output logic                           o_push_checked,
    output logic [COUNT_WIDTH-1:0]         o_push_count,
    output logic [ert_pkg::NOW_W-1:0]      o_push_now
);
    import ert_pkg::*;

    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [INTERVAL_W-1:0]  r_phase;
    logic [INTERVAL_W-1:0]  n_phase;
    logic [INTERVAL_W-1:0]  w_phase_inc;
    logic [INTERVAL_W-1:0]  w_limit;
    logic                   w_hit;
    logic                   w_accept;

    assign w_accept = i_in_valid && i_push_ready;

    // Classify: a zero interval behaves as one; phase wrap also checks
    always_comb begin
        w_limit     = (i_check_interval == '0) ? INTERVAL_W'(1) : i_check_interval;
        w_phase_inc = r_phase + INTERVAL_W'(1);
        w_hit       = (w_phase_inc >= w_limit) || (w_phase_inc == '0);
        n_count     = r_count + COUNT_WIDTH'(1);
        n_phase     = w_hit ? '0 : w_phase_inc;
    end

    // Event counter and interval phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
            r_phase <= n_phase;
        end
    end

    // Classified word goes straight into the queue
    assign o_in_ready     = i_push_ready;
    assign o_push_valid   = i_in_valid;
    assign o_push_checked = w_hit;
    assign o_push_count   = n_count;
    assign o_push_now     = i_now_ns;

endmodule

/* src/ert_queue.sv */
module ert_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output logic [DATA_W-1:0] o_pop_data
);
    localparam int DEPTH  = 2;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_fill != FILL_W'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

endmodule

/* src/ert_back.sv */
module ert_back #(
    parameter int COUNT_WIDTH = ert_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_pop_valid,
    output logic                        o_pop_ready,
    input  logic                        i_item_checked,
    input  logic [COUNT_WIDTH-1:0]      i_item_count,
    input  logic [ert_pkg::NOW_W-1:0]   i_item_now,
    input  ert_pkg::t_rate_cfg          i_cfg,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_checked,
    output logic [ert_pkg::PAUSE_W-1:0] o_pause_ns
);
    import ert_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int MUL_W     = 32;
    localparam int MUL_STEPS = 4;
    localparam int STEP_W    = 3;
    localparam int BIT_W     = $clog2(PAUSE_W);
    localparam int D_W       = COUNT_WIDTH + PAUSE_W;

    logic [2:0]             r_state, n_state;
    logic [STEP_W-1:0]      r_step, n_step;
    logic [1:0]             r_psel, n_psel;
    logic [2*MUL_W-1:0]     r_prod, n_prod;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [NOW_W-1:0]       r_elapsed, n_elapsed;
    logic                   r_late, n_late;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic [COUNT_WIDTH-1:0] r_rem, n_rem;
    logic [PAUSE_W-1:0]     r_quo, n_quo;
    logic [BIT_W-1:0]       r_bit, n_bit;
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_checked, n_out_checked;
    logic [PAUSE_W-1:0]     r_out_pause, n_out_pause;

    logic                   w_slot_free;
    logic [2*MUL_W-1:0]     w_count_ext;
    logic [MUL_W-1:0]       w_mul_a;
    logic [MUL_W-1:0]       w_mul_b;
    logic [2*MUL_W-1:0]     w_mul_p;
    logic [ACC_W-1:0]       w_term;
    logic [ACC_W-1:0]       w_acc_sum;
    logic                   w_acc_pos;
    logic [D_W-1:0]         w_div;
    logic [COUNT_WIDTH:0]   w_trial;
    logic                   w_fits;
    logic [COUNT_WIDTH-1:0] w_rem_next;

    assign w_slot_free = !r_out_valid || i_out_ready;

    // Shared 32x32 multiplier: count halves times 1e9, then rate times elapsed halves
    always_comb begin
        w_count_ext = (2*MUL_W)'(r_count);
        w_mul_a = r_step[1] ? i_cfg.target_rate
                : (r_step[0] ? w_count_ext[2*MUL_W-1:MUL_W] : w_count_ext[MUL_W-1:0]);
        w_mul_b = r_step[1] ? (r_step[0] ? r_elapsed[2*MUL_W-1:MUL_W] : r_elapsed[MUL_W-1:0])
                : MUL_W'(NS_PER_SEC);
        w_mul_p = (2*MUL_W)'(w_mul_a) * (2*MUL_W)'(w_mul_b);
    end

    // Accumulate: add the count*1e9 terms, subtract the rate*elapsed terms
    always_comb begin
        w_term    = r_psel[0] ? (ACC_W'(r_prod) << MUL_W) : ACC_W'(r_prod);
        w_acc_sum = r_psel[1] ? (r_acc - w_term) : (r_acc + w_term);
        w_acc_pos = !r_acc[ACC_W-1] && (r_acc != '0);
        w_div     = r_acc[D_W-1:0];
    end

    // One restoring division step; quotient bits shift in behind the dividend bits
    always_comb begin
        w_trial    = {r_rem, r_quo[PAUSE_W-1]};
        w_fits     = (w_trial >= {1'b0, r_count});
        w_rem_next = w_fits ? COUNT_WIDTH'(w_trial - {1'b0, r_count})
                            : w_trial[COUNT_WIDTH-1:0];
    end

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        n_psel        = r_psel;
        n_prod        = r_prod;
        n_count       = r_count;
        n_elapsed     = r_elapsed;
        n_late        = r_late;
        n_acc         = r_acc;
        n_rem         = r_rem;
        n_quo         = r_quo;
        n_bit         = r_bit;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_checked = r_out_checked;
        n_out_pause   = r_out_pause;
        o_pop_ready   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_pop_valid) begin
                    if (i_item_checked) begin
                        o_pop_ready = 1'b1;
                        n_count     = i_item_count;
                        n_elapsed   = i_item_now - i_cfg.start_time_ns;
                        n_late      = (i_item_now < i_cfg.start_time_ns);
                        n_acc       = '0;
                        n_step      = '0;
                        n_state     = ST_MUL;
                    end else if (w_slot_free) begin
                        o_pop_ready   = 1'b1;
                        n_out_valid   = 1'b1;
                        n_out_checked = 1'b0;
                        n_out_pause   = '0;
                    end
                end
            end
            ST_MUL: begin
                if (r_step != STEP_W'(MUL_STEPS)) begin
                    n_prod = w_mul_p;
                    n_psel = r_step[1:0];
                end
                if (r_step != '0) begin
                    n_acc = w_acc_sum;
                end
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(MUL_STEPS)) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                // No pause when not above target or when time is before start
                if (w_acc_pos && !r_late) begin
                    n_rem   = w_div[D_W-1:PAUSE_W];
                    n_quo   = w_div[PAUSE_W-1:0];
                    n_bit   = '0;
                    n_state = ST_DIV;
                end else begin
                    n_quo   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                n_rem = w_rem_next;
                n_quo = {r_quo[PAUSE_W-2:0], w_fits};
                n_bit = r_bit + BIT_W'(1);
                if (r_bit == BIT_W'(PAUSE_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    n_out_valid   = 1'b1;
                    n_out_checked = 1'b1;
                    n_out_pause   = r_quo;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_step        <= n_step;
        r_psel        <= n_psel;
        r_prod        <= n_prod;
        r_count       <= n_count;
        r_elapsed     <= n_elapsed;
        r_late        <= n_late;
        r_acc         <= n_acc;
        r_rem         <= n_rem;
        r_quo         <= n_quo;
        r_bit         <= n_bit;
        r_out_checked <= n_out_checked;
        r_out_pause   <= n_out_pause;
    end

    assign o_out_valid = r_out_valid;
    assign o_checked   = r_out_checked;
    assign o_pause_ns  = r_out_pause;

endmodule

/* src/ert_checker.sv */
module ert_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_checked,
    input logic [ert_pkg::PAUSE_W-1:0] o_pause_ns
);
    import ert_pkg::*;

    // A result word stays up until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result word dropped before acceptance");

    // Pause never exceeds one second
    a_pause_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pause_ns <= NS_PER_SEC))
        else $error("pause above one second");

    // Only a checking event can carry a pause
    a_pause_unchecked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_checked) |-> (o_pause_ns == '0))
        else $error("pause reported without a rate check");

    // Reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind event_rate_throttle_unit ert_checker u_ert_checker (.*);

/* tb/sv/pause_checker.sv */
module pause_checker #(
    parameter int COUNT_WIDTH = ert_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [ert_pkg::NOW_W-1:0]       i_now_ns,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_checked,
    input  logic [ert_pkg::PAUSE_W-1:0]     i_pause_ns,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [ert_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ert_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import ert_pkg::*;

    typedef struct packed {
        logic               checked;
        logic [PAUSE_W-1:0] pause_ns;
    } t_throttle_word;

    // Result words still owed by the block, oldest first
    t_throttle_word pause_queue[$];

    // Shadow of the settings and the event counters
    logic [TARGET_W-1:0]    rate_q     = TARGET_RATE_RST;
    logic [INTERVAL_W-1:0]  interval_q = CHECK_INTERVAL_RST;
    logic [NOW_W-1:0]       start_q    = START_TIME_RST;
    logic [COUNT_WIDTH-1:0] events_q   = '0;
    logic [INTERVAL_W-1:0]  phase_q    = '0;
    int                     fails      = 0;

    // Pause owed at a check: (events*1e9 - rate*elapsed) / events, truncated
    function automatic logic [PAUSE_W-1:0] hold_off_ns(
        input logic [COUNT_WIDTH-1:0] events,
        input logic [NOW_W-1:0]       now
    );
        logic [127:0] owed;
        logic [127:0] allowed;
        // no events yet, or time before start: average rate is not above target
        if (events == '0 || now < start_q)
            return '0;
        owed    = 128'(events) * 128'(NS_PER_SEC);
        allowed = 128'(rate_q) * 128'(now - start_q);
        if (owed <= allowed)
            return '0;
        return PAUSE_W'((owed - allowed) / 128'(events));
    endfunction

    always @(posedge i_clk) begin
        t_throttle_word        seen;
        t_throttle_word        want;
        t_throttle_word        next;
        logic [INTERVAL_W-1:0] limit;
        if (!i_rst_n) begin
            rate_q     = TARGET_RATE_RST;
            interval_q = CHECK_INTERVAL_RST;
            start_q    = START_TIME_RST;
            events_q   = '0;
            phase_q    = '0;
            pause_queue.delete();
        end else begin
            // register writes; unknown indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_TARGET_RATE:    rate_q     = i_cfg_data[TARGET_W-1:0];
                    REG_CHECK_INTERVAL: interval_q = i_cfg_data[INTERVAL_W-1:0];
                    REG_START_TIME:     start_q    = i_cfg_data;
                    default: ;
                endcase
            end

            // compare a result word against the oldest expectation
            if (i_out_valid === 1'b1 && i_out_ready) begin
                seen.checked  = i_checked;
                seen.pause_ns = i_pause_ns;
                if (pause_queue.size() == 0) begin
                    $error("result word with nothing expected: checked %0d, pause_ns %0d",
                           seen.checked, seen.pause_ns);
                    fails++;
                end else begin
                    want = pause_queue.pop_front();
                    if (seen.checked !== want.checked) begin
                        $error("checked: expected %0d, got %0d", want.checked, seen.checked);
                        fails++;
                    end
                    if (seen.pause_ns !== want.pause_ns) begin
                        $error("pause_ns: expected %0d, got %0d", want.pause_ns, seen.pause_ns);
                        fails++;
                    end
                end
            end

            // event word: count it and decide whether it checks
            if (i_in_valid && i_in_ready) begin
                limit    = (interval_q == '0) ? INTERVAL_W'(1) : interval_q;
                events_q = events_q + 1'b1;
                phase_q  = phase_q + 1'b1;
                next     = '0;
                // a lowered interval below the current phase checks at once
                if (phase_q >= limit || phase_q == '0) begin
                    phase_q       = '0;
                    next.checked  = 1'b1;
                    next.pause_ns = hold_off_ns(events_q, i_now_ns);
                end
                pause_queue.push_back(next);
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= pause_queue.size();
    end

endmodule

/* tb/sv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ert_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          HOLD_LEN       = 300;
    localparam int          SETTLE_CYCLES  = 50;
    localparam int          PHASES         = 8;
    localparam int          PHASE_ITEMS    = 105;
    localparam logic [63:0] ALL_ONES       = '1;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    logic [NOW_W-1:0]       i_now_ns    = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic                   o_checked;
    logic [PAUSE_W-1:0]     o_pause_ns;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    int  fail_count;
    int  outstanding;
    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    logic hold_go      = 1'b0;
    int  hold_left     = 0;
    int  quiet         = 0;

    // Stimulus-side view of the settings, used to aim timestamps
    logic [63:0]         events_sent = '0;
    logic [TARGET_W-1:0] aim_rate    = TARGET_RATE_RST;
    logic [NOW_W-1:0]    cur_start   = START_TIME_RST;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    event_rate_throttle_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_now_ns    (i_now_ns),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_checked   (o_checked),
        .o_pause_ns  (o_pause_ns),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pause_checker u_pause_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_now_ns      (i_now_ns),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_checked     (o_checked),
        .i_pause_ns    (o_pause_ns),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Result side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_go) begin
            hold_left   <= HOLD_LEN;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: too many cycles without any word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("event_rate_throttle_unit test failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Offer one event word, with random idle cycles ahead of it
    task automatic send_event(input logic [NOW_W-1:0] now);
        int gaps;
        gaps = 0;
        while ($urandom_range(99) < send_idle_pct)
            gaps++;
        if (gaps != 0) begin
            i_in_valid <= 1'b0;
            repeat (gaps) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_now_ns   <= now;
        do @(posedge i_clk); while (!o_in_ready);
        events_sent++;
    endtask

    // Stop offering and wait until every result word is back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_TARGET_RATE)
            aim_rate = data[TARGET_W-1:0];
        else if (idx == REG_START_TIME)
            cur_start = data;
    endtask

    function automatic logic [TARGET_W-1:0] pick_rate();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2, 3:    return TARGET_W'($urandom_range(100_000, 1));
            4:       return TARGET_W'($urandom_range(50_000_000, 1));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [INTERVAL_W-1:0] pick_interval();
        case ($urandom_range(5))
            0:       return '0;
            1:       return INTERVAL_W'(1);
            2, 3, 4: return INTERVAL_W'($urandom_range(6, 2));
            default: return INTERVAL_W'($urandom_range(40, 7));
        endcase
    endfunction

    function automatic logic [NOW_W-1:0] pick_start();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom} >> $urandom_range(40, 1);
        endcase
    endfunction

    // Timestamps mostly near the break-even point of the average rate,
    // so checks land on both sides of the target
    function automatic logic [NOW_W-1:0] pick_now();
        logic [95:0]      span;
        logic [NOW_W-1:0] ideal;
        logic [NOW_W-1:0] jitter;
        int               sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return cur_start;
        if (sel < 27)
            return (cur_start == '0) ? '0 : ({$urandom, $urandom} % cur_start);
        if (sel < 37)
            return {$urandom, $urandom};
        if (aim_rate == '0) begin
            ideal = NOW_W'($urandom);
        end else begin
            span  = 96'(events_sent + 1) * 96'(NS_PER_SEC);
            ideal = NOW_W'(span / 96'(aim_rate));
        end
        jitter = {$urandom, $urandom} % (ideal + 1'b1);
        return cur_start + (ideal >> 1) + jitter;
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero elapsed, a plain pause, a far-future stamp
        send_event(64'd0);
        send_event(64'd1000);
        send_event(ALL_ONES);
        wait_idle();
        // zero target rate gives the full second
        write_reg(REG_TARGET_RATE, 64'd0);
        send_event(64'd5);
        wait_idle();
        write_reg(REG_TARGET_RATE, 64'hFFFF_FFFF);
        send_event(64'd1);
        send_event(64'h8000_0000_0000_0000);
        wait_idle();
        // latest start: stamps before it, then exactly on it
        write_reg(REG_START_TIME, ALL_ONES);
        send_event(64'd123);
        send_event(ALL_ONES);
        wait_idle();
        write_reg(REG_START_TIME, 64'd1_000_000);
        write_reg(REG_TARGET_RATE, 64'd1000);
        send_event(64'd999_999);
        send_event(64'd1_003_000);
        wait_idle();
        // zero interval checks every event
        write_reg(REG_CHECK_INTERVAL, 64'd0);
        send_event(64'd1_000_500);
        send_event(64'd1_001_000);
        wait_idle();
        write_reg(REG_CHECK_INTERVAL, 64'd3);
        repeat (3) send_event(64'd1_002_000);
        wait_idle();
        write_reg(REG_CHECK_INTERVAL, 64'hFFFF);
        repeat (3) send_event(64'd1_004_000);
        wait_idle();
        // interval lowered below the running phase
        write_reg(REG_CHECK_INTERVAL, 64'd2);
        send_event(64'd1_005_000);
        wait_idle();
        write_reg(REG_UNUSED, {$urandom, $urandom});
        send_event(64'd1_000_001);

        // random phases, each with fresh settings and its own idling pattern
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            write_reg(REG_TARGET_RATE, {$urandom, pick_rate()});
            write_reg(REG_CHECK_INTERVAL, {$urandom, 16'($urandom), pick_interval()});
            write_reg(REG_START_TIME, pick_start());
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 81;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 81;
                end
                default: begin
                    send_idle_pct = 32;
                    stall_pct     = 32;
                end
            endcase
            // long result hold-off while events keep coming
            if (p == 0) begin
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_event(pick_now());
        end

        wait_idle();
        if (fail_count == 0)
            $display("event_rate_throttle_unit test passed");
        else
            $display("event_rate_throttle_unit test failed");
        $finish;
    end

endmodule
